### src/assert_macros.svh
// shared assertion macros, clocked on clk and disabled during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AST_IMPLY(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);
`define AST_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define AST_IMPLY(lbl, cond, prop, msg)
`define AST_NEXT(lbl, cond, prop, msg)
`endif
`endif

### src/fpcd_pkg.sv
package fpcd_pkg;

  localparam int POS_WIDTH      = 32;
  localparam int TRIG_FRAC_BITS = 15;

  localparam int FIELD_W    = 32;
  localparam int ANG_W      = 9;
  localparam int BAND_W     = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int D_W      = POS_WIDTH + 1;
  localparam int NRM_W    = TRIG_FRAC_BITS + 2;
  localparam int PROD_W   = D_W + NRM_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int THR_W    = BAND_W + TRIG_FRAC_BITS - 1;
  localparam int CMP_W    = ((SUM_W > THR_W) ? SUM_W : THR_W + 1) + 1;
  localparam int HGT_W    = ((D_W > BAND_W) ? D_W : BAND_W + 1) + 1;
  localparam int SIGN_IDX = (POS_WIDTH <= FIELD_W) ? POS_WIDTH - 1 : FIELD_W - 1;

  localparam logic [ANG_W-1:0] DEG_90  = ANG_W'(90);
  localparam logic [ANG_W-1:0] DEG_180 = ANG_W'(180);
  localparam logic [ANG_W-1:0] DEG_270 = ANG_W'(270);
  localparam logic [ANG_W-1:0] DEG_360 = ANG_W'(360);

  localparam int QUARTER_N    = 91;
  localparam int QIDX_W       = $clog2(QUARTER_N);
  localparam int TAYLOR_TERMS = 8;
  localparam int Q30_FRAC     = 30;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_CENTER_Z   = 3'd2,
    REG_FACING     = 3'd3,
    REG_FULL_WIDTH = 3'd4,
    REG_BAND_ABOVE = 3'd5,
    REG_BAND_BELOW = 3'd6
  } cfg_reg_e;

  typedef logic [TRIG_FRAC_BITS:0] trig_t;
  typedef trig_t sine_rom_t [QUARTER_N];

  typedef struct packed {
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] nz;
  } normal_t;

  // sin(k deg) by fixed point taylor series in q2.30, rounded to the table format
  function automatic trig_t quarter_sine(input int unsigned k);
    logic [63:0] x;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] r;
    x    = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
    sum  = x;
    term = x;
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      term = (term * x + (64'd1 << (Q30_FRAC - 1))) >> Q30_FRAC;
      term = (term * x + (64'd1 << (Q30_FRAC - 1))) >> Q30_FRAC;
      // divide by (2n)(2n+1), rounded half up
      unique case (n)
        1:       term = (term + 64'd3) / 64'd6;
        2:       term = (term + 64'd10) / 64'd20;
        3:       term = (term + 64'd21) / 64'd42;
        4:       term = (term + 64'd36) / 64'd72;
        5:       term = (term + 64'd55) / 64'd110;
        6:       term = (term + 64'd78) / 64'd156;
        7:       term = (term + 64'd105) / 64'd210;
        default: term = (term + 64'd136) / 64'd272;
      endcase
      if ((n % 2) == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    r = (sum + (64'd1 << (Q30_FRAC - TRIG_FRAC_BITS - 1))) >> (Q30_FRAC - TRIG_FRAC_BITS);
    if (r > (64'd1 << TRIG_FRAC_BITS)) begin
      r = 64'd1 << TRIG_FRAC_BITS;
    end
    return trig_t'(r);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k < QUARTER_N; k++) begin
      rom[k] = quarter_sine(k);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // low POS_WIDTH bits of a field as two's complement, widened to D_W
  function automatic logic signed [D_W-1:0] pos_ext(input logic [FIELD_W-1:0] v);
    logic [D_W-1:0] r;
    for (int i = 0; i < D_W; i++) begin
      if (i < POS_WIDTH) begin
        r[i] = (i < FIELD_W) ? v[i % FIELD_W] : 1'b0;
      end else begin
        r[i] = (POS_WIDTH <= FIELD_W) ? v[SIGN_IDX] : 1'b0;
      end
    end
    return $signed(r);
  endfunction

endpackage

### src/fpcd_stream_if.sv
interface fpcd_track_if;
  import fpcd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [FIELD_W-1:0]  prev_x;
  logic signed [FIELD_W-1:0]  prev_z;
  logic signed [FIELD_W-1:0]  now_x;
  logic signed [FIELD_W-1:0]  now_y;
  logic signed [FIELD_W-1:0]  now_z;

  modport source (output valid, prev_x, prev_z, now_x, now_y, now_z, input ready);
  modport sink (input valid, prev_x, prev_z, now_x, now_y, now_z, output ready);
endinterface

interface fpcd_flag_if;
  logic valid;
  logic ready;
  logic crossed;

  modport source (output valid, crossed, input ready);
  modport sink (input valid, crossed, output ready);
endinterface

### src/fpcd_normal.sv
module fpcd_normal (
  input  logic [fpcd_pkg::ANG_W-1:0] facing,
  output fpcd_pkg::normal_t          nrm
);
  import fpcd_pkg::*;

  logic [ANG_W-1:0] ang_a;
  logic [ANG_W-1:0] ang_b_raw;
  logic [ANG_W-1:0] ang_b;

  // fold the angle onto the quarter wave table
  function automatic logic signed [NRM_W-1:0] sine_of(input logic [ANG_W-1:0] a);
    logic [QIDX_W-1:0]       idx;
    logic                    neg;
    logic signed [NRM_W-1:0] mag;
    priority if (a < DEG_90) begin
      idx = QIDX_W'(a);
      neg = 1'b0;
    end else if (a < DEG_180) begin
      idx = QIDX_W'(DEG_180 - a);
      neg = 1'b0;
    end else if (a < DEG_270) begin
      idx = QIDX_W'(a - DEG_180);
      neg = 1'b1;
    end else begin
      idx = QIDX_W'(DEG_360 - a);
      neg = 1'b1;
    end
    mag = $signed(NRM_W'(SINE_ROM[idx]));
    return neg ? -mag : mag;
  endfunction

  always_comb begin
    ang_a     = (facing >= DEG_360) ? facing - DEG_360 : facing;
    ang_b_raw = ang_a + DEG_90;
    ang_b     = (ang_b_raw >= DEG_360) ? ang_b_raw - DEG_360 : ang_b_raw;
    nrm.nz    = sine_of(ang_a);
    nrm.nx    = sine_of(ang_b);
  end

endmodule

### src/finite_plane_crossing_detector.sv
// pipeline: an accepted track beat passes through every stage below before its verdict beat is valid
// throughput: one beat per cycle; each stage holds its beat only while the next is full
// stages: offsets and normal lookup, six products with height gate, sums, width gate
// reset (rst, synchronous): clears all config registers to zero and every stage valid
`include "assert_macros.svh"

module finite_plane_crossing_detector (
  input  logic                            clk,
  input  logic                            rst,
  fpcd_track_if.sink                      track,
  fpcd_flag_if.source                     verdict,
  input  logic                            cfg_wen,
  input  logic [fpcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpcd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fpcd_pkg::*;

  // configuration
  logic [FIELD_W-1:0] center_x;
  logic [FIELD_W-1:0] center_y;
  logic [FIELD_W-1:0] center_z;
  logic [ANG_W-1:0]   facing_degrees;
  logic [BAND_W-1:0]  full_width;
  logic [BAND_W-1:0]  band_above;
  logic [BAND_W-1:0]  band_below;

  normal_t nrm;

  // stage ready chain
  logic r1, r2, r3, r4;
  logic v1, v2, v3, v4;

  // stage 1
  logic signed [D_W-1:0]   dx1, dy1, dz1, pdx1, pdz1;
  logic signed [NRM_W-1:0] nx1, nz1;
  // stage 2
  logic signed [PROD_W-1:0] dx_nz2, dz_nx2, pdx_nx2, pdz_nz2, dx_nx2, dz_nz2;
  logic                     h_ok2;
  // stage 3
  logic signed [SUM_W-1:0] along3;
  logic                    prev_neg3;
  logic                    now_neg3;
  logic                    h_ok3;
  // stage 4
  logic crossed_q;

  // combinational helpers
  logic signed [D_W-1:0]   cx, cy, cz;
  logic signed [HGT_W-1:0] dy_w, above_w, below_w;
  logic signed [SUM_W-1:0] prev_sum, now_sum;
  logic signed [CMP_W-1:0] along_w, thr_w;
  logic                    w_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x       <= '0;
      center_y       <= '0;
      center_z       <= '0;
      facing_degrees <= '0;
      full_width     <= '0;
      band_above     <= '0;
      band_below     <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_CENTER_X:   center_x       <= cfg_data;
        REG_CENTER_Y:   center_y       <= cfg_data;
        REG_CENTER_Z:   center_z       <= cfg_data;
        REG_FACING:     facing_degrees <= cfg_data[ANG_W-1:0];
        REG_FULL_WIDTH: full_width     <= cfg_data[BAND_W-1:0];
        REG_BAND_ABOVE: band_above     <= cfg_data[BAND_W-1:0];
        REG_BAND_BELOW: band_below     <= cfg_data[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  fpcd_normal u_normal (
    .facing (facing_degrees),
    .nrm    (nrm)
  );

  assign r4 = !v4 || verdict.ready;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;

  assign track.ready     = r1;
  assign verdict.valid   = v4;
  assign verdict.crossed = crossed_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r1) v1 <= track.valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
    end
  end

  always_comb begin
    cx = pos_ext(center_x);
    cy = pos_ext(center_y);
    cz = pos_ext(center_z);
  end

  // stage 1: offsets from the plane centre
  always_ff @(posedge clk) begin
    if (r1) begin
      dx1  <= pos_ext(track.now_x) - cx;
      dy1  <= pos_ext(track.now_y) - cy;
      dz1  <= pos_ext(track.now_z) - cz;
      pdx1 <= pos_ext(track.prev_x) - cx;
      pdz1 <= pos_ext(track.prev_z) - cz;
      nx1  <= nrm.nx;
      nz1  <= nrm.nz;
    end
  end

  always_comb begin
    dy_w    = HGT_W'(dy1);
    above_w = HGT_W'($signed({1'b0, band_above}));
    below_w = HGT_W'($signed({1'b0, band_below}));
  end

  // stage 2: products and height band
  always_ff @(posedge clk) begin
    if (r2) begin
      dx_nz2  <= dx1 * nz1;
      dz_nx2  <= dz1 * nx1;
      pdx_nx2 <= pdx1 * nx1;
      pdz_nz2 <= pdz1 * nz1;
      dx_nx2  <= dx1 * nx1;
      dz_nz2  <= dz1 * nz1;
      h_ok2   <= !(dy_w > above_w) && !((dy_w + below_w) < 0);
    end
  end

  always_comb begin
    prev_sum = SUM_W'(pdx_nx2) + SUM_W'(pdz_nz2);
    now_sum  = SUM_W'(dx_nx2) + SUM_W'(dz_nz2);
  end

  // stage 3: tangent offset and side of each position
  always_ff @(posedge clk) begin
    if (r3) begin
      along3    <= SUM_W'(dz_nx2) - SUM_W'(dx_nz2);
      prev_neg3 <= prev_sum[SUM_W-1];
      now_neg3  <= now_sum[SUM_W-1];
      h_ok3     <= h_ok2;
    end
  end

  always_comb begin
    along_w = CMP_W'(along3);
    thr_w   = $signed(CMP_W'({full_width, {(TRIG_FRAC_BITS - 1){1'b0}}}));
    w_ok    = !(along_w > thr_w) && !(along_w < -thr_w);
  end

  // stage 4: width gate and verdict
  always_ff @(posedge clk) begin
    if (r4) begin
      crossed_q <= w_ok && h_ok3 && (prev_neg3 != now_neg3);
    end
  end

  `AST_IMPLY(a_rst_clears, $past(rst), !(v1 || v2 || v3 || v4), "valid left after reset")
  `AST_NEXT(a_accept_enters, track.valid && track.ready, v1, "accepted beat lost at entry")
  `AST_NEXT(a_stage_moves, v2 && r3, v3, "beat dropped between stages")
  `AST_NEXT(a_height_blocks, v3 && r4 && !h_ok3, !crossed_q, "crossing outside height band")

endmodule

### bench/tb_finite_plane_crossing_detector.sv
`timescale 1ns / 1ps

module tb_finite_plane_crossing_detector;
  import fpcd_pkg::*;

  localparam logic [63:0] PI_FIX30 = 64'd3373259426;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned END_WAIT = 8;
  localparam int unsigned IDLE_PCT = 12;
  localparam int RAND_PHASES = 20;
  localparam int BEATS_PER_PHASE = 100;

  typedef struct packed {
    logic signed [FIELD_W-1:0] prev_x;
    logic signed [FIELD_W-1:0] prev_z;
    logic signed [FIELD_W-1:0] now_x;
    logic signed [FIELD_W-1:0] now_y;
    logic signed [FIELD_W-1:0] now_z;
  } track_t;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [ANG_W-1:0]   facing;
    logic [BAND_W-1:0]  width;
    logic [BAND_W-1:0]  above;
    logic [BAND_W-1:0]  below;
  } plane_cfg_t;

  typedef struct packed {
    logic [2:0] plane_sel;
    track_t     beat;
    logic       typed;
    logic       want;
  } dir_row_t;

  localparam plane_cfg_t DIR_PLANES [7] = '{
    '{32'sd0, 32'sd0, 32'sd0, 9'd0, 31'd0, 31'd0, 31'd0},
    '{32'sd256, 32'sd0, -32'sd512, 9'd90, 31'd2560, 31'd512, 31'd512},
    '{32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 9'd450, 31'h7FFFFFFF, 31'h7FFFFFFF,
      31'h7FFFFFFF},
    '{32'sd0, -32'sd1024, 32'sd0, 9'd359, 31'd0, 31'd0, 31'd2048},
    '{32'sd1000, 32'sd0, 32'sd1000, 9'd180, 31'd4096, 31'd4096, 31'd0},
    '{-32'sd5000, 32'sd300, 32'sd7000, 9'd270, 31'd8192, 31'd1024, 31'd1024},
    '{32'sd0, 32'sd0, 32'sd0, 9'd511, 31'd100000, 31'd256, 31'd256}
  };

  // rows on the reset plane carry their verdict; the rest go through the predictor
  localparam dir_row_t DIR_ROWS [26] = '{
    // reset plane: normal +x, zero width, zero band
    '{3'd0, '{-32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1, 1'b1},
    '{3'd0, '{32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1, 1'b0},
    '{3'd0, '{32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'sd0, 32'sd0}, 1'b1, 1'b1},
    '{3'd0, '{32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'sd0, 32'sd0}, 1'b1, 1'b1},
    '{3'd0, '{-32'sd5, 32'sd0, -32'sd1, 32'sd0, 32'sd0}, 1'b1, 1'b0},
    '{3'd0, '{-32'sd256, 32'sd0, 32'sd256, 32'sd0, 32'sd1}, 1'b1, 1'b0},
    '{3'd0, '{-32'sd256, 32'sd0, 32'sd256, 32'sd1, 32'sd0}, 1'b1, 1'b0},
    '{3'd0, '{-32'sd256, 32'sd0, 32'sd256, -32'sd1, 32'sd0}, 1'b1, 1'b0},
    '{3'd0, '{-32'sd256, 32'sd0, 32'sd256, 32'h7FFFFFFF, 32'h80000000}, 1'b1, 1'b0},
    '{3'd0, '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1, 1'b0},
    // facing east, width and band edges
    '{3'd1, '{32'sd256, -32'sd1024, 32'sd256, 32'sd0, 32'sd0}, 1'b0, 1'b0},
    '{3'd1, '{32'sd256, -32'sd1024, 32'sd1536, 32'sd0, 32'sd0}, 1'b0, 1'b0},
    '{3'd1, '{32'sd256, -32'sd1024, 32'sd1537, 32'sd0, 32'sd0}, 1'b0, 1'b0},
    '{3'd1, '{32'sd256, -32'sd1024, 32'sd256, 32'sd512, 32'sd0}, 1'b0, 1'b0},
    '{3'd1, '{32'sd256, -32'sd1024, 32'sd256, 32'sd513, 32'sd0}, 1'b0, 1'b0},
    '{3'd1, '{32'sd256, -32'sd1024, 32'sd256, -32'sd513, 32'sd0}, 1'b0, 1'b0},
    // wrapped heading, extreme centre and gates
    '{3'd2, '{32'sd0, 32'sd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000}, 1'b0, 1'b0},
    '{3'd2, '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF},
      1'b0, 1'b0},
    '{3'd2, '{-32'sd1, 32'sd1, 32'sd1, -32'sd1, -32'sd1}, 1'b0, 1'b0},
    // zero width: only the normal line passes
    '{3'd3, '{-32'sd1, 32'sd5, 32'sd0, -32'sd1024, 32'sd0}, 1'b0, 1'b0},
    '{3'd3, '{-32'sd1, 32'sd5, 32'sd1, -32'sd3072, 32'sd0}, 1'b0, 1'b0},
    '{3'd4, '{32'sd2000, 32'sd1000, 32'sd0, 32'sd0, 32'sd1000}, 1'b0, 1'b0},
    '{3'd4, '{32'sd2000, 32'sd1000, 32'sd0, 32'sd4097, 32'sd1000}, 1'b0, 1'b0},
    '{3'd4, '{32'sd2000, 32'sd1000, 32'sd0, -32'sd1, 32'sd1000}, 1'b0, 1'b0},
    '{3'd5, '{-32'sd10000, 32'sd7000, 32'sd0, 32'sd300, 32'sd7000}, 1'b0, 1'b0},
    '{3'd6, '{-32'sd1000, -32'sd1000, 32'sd1000, 32'sd10, 32'sd1000}, 1'b0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_wen;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fpcd_track_if track_bus ();
  fpcd_flag_if verdict_bus ();

  finite_plane_crossing_detector u_top (
    .clk       (clk),
    .rst       (rst),
    .track     (track_bus),
    .verdict   (verdict_bus),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  plane_cfg_t plane;
  logic crossing_q[$];
  logic offer_typed;
  logic offer_want;
  logic calm;
  int unsigned quiet_cycles;
  int unsigned error_count = 0;
  int unsigned beats_taken = 0;
  int unsigned crossings_seen = 0;
  int unsigned planes_loaded;

  // sin(k deg) for k in 0..90, q2.30 taylor series rounded to q1.15
  function automatic longint quarter_wave(int unsigned k);
    logic [63:0] x, acc, term, div, r;
    x = (64'(k) * PI_FIX30 + 64'd90) / 64'd180;
    acc = x;
    term = x;
    for (int n = 1; n <= 8; n++) begin
      div = 64'(2 * n) * 64'(2 * n + 1);
      term = (term * x + (64'd1 << 29)) >> 30;
      term = (term * x + (64'd1 << 29)) >> 30;
      term = (term + div / 2) / div;
      if (n % 2 == 1) begin
        acc = (acc >= term) ? acc - term : 64'd0;
      end else begin
        acc = acc + term;
      end
    end
    r = (acc + (64'd1 << (30 - TRIG_FRAC_BITS - 1))) >> (30 - TRIG_FRAC_BITS);
    if (r > (64'd1 << TRIG_FRAC_BITS)) begin
      r = 64'd1 << TRIG_FRAC_BITS;
    end
    return longint'(r);
  endfunction

  function automatic longint sine_of_deg(int unsigned a);
    int unsigned q, rem;
    longint v;
    q = a / 90;
    rem = a % 90;
    v = (q % 2 == 1) ? quarter_wave(90 - rem) : quarter_wave(rem);
    return (q >= 2) ? -v : v;
  endfunction

  function automatic logic predict_crossed(track_t t, plane_cfg_t c);
    int unsigned a;
    longint nz, nx, dx, dy, dz, pdx, pdz, along, prev_dot, now_dot, thr;
    logic pass;
    a = c.facing % 360;
    nz = sine_of_deg(a);
    nx = sine_of_deg((a + 90) % 360);
    dx = longint'(t.now_x) - longint'(c.cx);
    dy = longint'(t.now_y) - longint'(c.cy);
    dz = longint'(t.now_z) - longint'(c.cz);
    pdx = longint'(t.prev_x) - longint'(c.cx);
    pdz = longint'(t.prev_z) - longint'(c.cz);
    along = dz * nx - dx * nz;
    if (along < 0) begin
      along = -along;
    end
    thr = longint'(c.width) <<< (TRIG_FRAC_BITS - 1);
    pass = (along <= thr) && (dy <= longint'(c.above)) && (dy >= -longint'(c.below));
    prev_dot = pdx * nx + pdz * nz;
    now_dot = dx * nx + dz * nz;
    return pass && ((prev_dot < 0) != (now_dot < 0));
  endfunction

  function automatic longint signed_range(longint lim);
    if (lim > 64'sh7FFFFFFF) begin
      lim = 64'sh7FFFFFFF;
    end
    return longint'($urandom_range(0, 32'(2 * lim))) - lim;
  endfunction

  function automatic logic [BAND_W-1:0] pick_length();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return BAND_W'($urandom);
      default: return BAND_W'($urandom_range(0, 1 << 17));
    endcase
  endfunction

  function automatic logic signed [31:0] pick_centre();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return $urandom_range(0, 1 << 21) - (1 << 20);
    endcase
  endfunction

  function automatic plane_cfg_t random_plane();
    plane_cfg_t p;
    p.cx = pick_centre();
    p.cy = pick_centre();
    p.cz = pick_centre();
    p.facing = ANG_W'($urandom_range(0, 511));
    p.width = pick_length();
    p.above = pick_length();
    p.below = pick_length();
    return p;
  endfunction

  function automatic longint height_offset(logic [BAND_W-1:0] band);
    longint lim;
    lim = longint'(band) + (longint'(band) >>> 3) + 2;
    if (lim > 64'shFFFFFFFF) begin
      lim = 64'shFFFFFFFF;
    end
    return longint'($urandom_range(0, 32'(lim)));
  endfunction

  // place the current point near the plane and the previous one mostly on the far side
  function automatic track_t random_beat(plane_cfg_t c);
    track_t b;
    int unsigned a;
    longint nz, nx, wlim, s, s2, tn, tp, dx, dz, pdx, pdz, dy;
    if ($urandom_range(0, 3) == 0) begin
      b = {$urandom, $urandom, $urandom, $urandom, $urandom};
      return b;
    end
    a = c.facing % 360;
    nz = sine_of_deg(a);
    nx = sine_of_deg((a + 90) % 360);
    wlim = (longint'(c.width) >>> 1) + (longint'(c.width) >>> 3) + 2;
    s = signed_range(wlim);
    s2 = signed_range(wlim);
    tn = signed_range(longint'($urandom_range(1, 1 << 16)));
    tp = -tn * longint'($urandom_range(1, 4)) + signed_range(16);
    dx = (tn * nx - s * nz) >>> TRIG_FRAC_BITS;
    dz = (tn * nz + s * nx) >>> TRIG_FRAC_BITS;
    pdx = (tp * nx - s2 * nz) >>> TRIG_FRAC_BITS;
    pdz = (tp * nz + s2 * nx) >>> TRIG_FRAC_BITS;
    if ($urandom_range(0, 15) == 0) begin
      dx = 0;
      dz = 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      pdx = 0;
      pdz = 0;
    end
    dy = $urandom_range(0, 1) ? height_offset(c.above) : -height_offset(c.below);
    b.prev_x = 32'(longint'(c.cx) + pdx);
    b.prev_z = 32'(longint'(c.cz) + pdz);
    b.now_x = 32'(longint'(c.cx) + dx);
    b.now_y = 32'(longint'(c.cy) + dy);
    b.now_z = 32'(longint'(c.cz) + dz);
    return b;
  endfunction

  task automatic reg_write(cfg_reg_e idx, logic [CFG_DATA_W-1:0] v);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
  endtask

  // bits above each register's width carry junk, the block must drop them
  task automatic apply_plane(plane_cfg_t p);
    logic [CFG_DATA_W-1:0] junk;
    reg_write(REG_CENTER_X, p.cx);
    reg_write(REG_CENTER_Y, p.cy);
    reg_write(REG_CENTER_Z, p.cz);
    junk = $urandom;
    junk[ANG_W-1:0] = p.facing;
    reg_write(REG_FACING, junk);
    junk = $urandom;
    junk[BAND_W-1:0] = p.width;
    reg_write(REG_FULL_WIDTH, junk);
    junk = $urandom;
    junk[BAND_W-1:0] = p.above;
    reg_write(REG_BAND_ABOVE, junk);
    junk = $urandom;
    junk[BAND_W-1:0] = p.below;
    reg_write(REG_BAND_BELOW, junk);
    cfg_wen <= 1'b0;
    plane = p;
    planes_loaded++;
  endtask

  task automatic send_track(track_t b, logic typed, logic want);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      track_bus.valid <= 1'b0;
      @(posedge clk);
    end
    track_bus.valid <= 1'b1;
    track_bus.prev_x <= b.prev_x;
    track_bus.prev_z <= b.prev_z;
    track_bus.now_x <= b.now_x;
    track_bus.now_y <= b.now_y;
    track_bus.now_z <= b.now_z;
    offer_typed <= typed;
    offer_want <= want;
    @(posedge clk);
    while (!track_bus.ready) begin
      @(posedge clk);
    end
  endtask

  // hold the sender until every verdict in flight has come back
  task automatic drain_verdicts();
    track_bus.valid <= 1'b0;
    @(posedge clk);
    while (crossing_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    track_t seen;
    logic want;
    if (rst) begin
      verdict_bus.ready <= 1'b0;
      quiet_cycles = 0;
    end else begin
      if (track_bus.valid && track_bus.ready) begin
        seen.prev_x = track_bus.prev_x;
        seen.prev_z = track_bus.prev_z;
        seen.now_x = track_bus.now_x;
        seen.now_y = track_bus.now_y;
        seen.now_z = track_bus.now_z;
        crossing_q.push_back(offer_typed ? offer_want : predict_crossed(seen, plane));
        beats_taken++;
      end
      if (verdict_bus.valid && verdict_bus.ready) begin
        if (crossing_q.size() == 0) begin
          $display("%0t: verdict beat with nothing expected, actual %0b", $time,
                   verdict_bus.crossed);
          error_count++;
        end else begin
          want = crossing_q.pop_front();
          if (verdict_bus.crossed !== want) begin
            $display("%0t: crossed mismatch, expected %0b actual %0b", $time, want,
                     verdict_bus.crossed);
            error_count++;
          end
          if (verdict_bus.crossed === 1'b1) begin
            crossings_seen++;
          end
        end
      end
      verdict_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      if ((track_bus.valid && track_bus.ready) || (verdict_bus.valid && verdict_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d verdicts outstanding", $time,
                 quiet_cycles, crossing_q.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int unsigned cur_sel;
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    track_bus.valid = 1'b0;
    track_bus.prev_x = '0;
    track_bus.prev_z = '0;
    track_bus.now_x = '0;
    track_bus.now_y = '0;
    track_bus.now_z = '0;
    offer_typed = 1'b0;
    offer_want = 1'b0;
    calm = 1'b0;
    plane = DIR_PLANES[0];
    planes_loaded = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cur_sel = 0;
    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].plane_sel != cur_sel) begin
        drain_verdicts();
        cur_sel = DIR_ROWS[i].plane_sel;
        apply_plane(DIR_PLANES[cur_sel]);
      end
      send_track(DIR_ROWS[i].beat, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain_verdicts();
      apply_plane(random_plane());
      calm <= (p >= 6 && p < 9);
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        send_track(random_beat(plane), 1'b0, 1'b0);
      end
    end

    drain_verdicts();
    calm <= 1'b0;
    repeat (END_WAIT) @(posedge clk);
    $display("covered %0d track beats over %0d plane settings, %0d crossings reported",
             beats_taken, planes_loaded, crossings_seen);
    $display("headings wrapped past 359, zero and full widths and bands, %0d errors",
             error_count);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/fpcd_pkg.sv
src/fpcd_stream_if.sv
src/fpcd_normal.sv
src/finite_plane_crossing_detector.sv
bench/tb_finite_plane_crossing_detector.sv
